### hdl/ncr_pkg.sv
package ncr_pkg;

    localparam logic [20:0] MAX_CODE  = 21'h10FFFF;
    localparam logic [20:0] SAT_CODE  = 21'h110000;
    localparam logic [20:0] REPL_CODE = 21'h00FFFD;
    localparam logic [20:0] SURR_LO   = 21'h00D800;
    localparam logic [20:0] SURR_HI   = 21'h00DFFF;
    localparam logic [20:0] LIM_1B    = 21'h000080;
    localparam logic [20:0] LIM_2B    = 21'h000800;
    localparam logic [20:0] LIM_3B    = 21'h010000;

    localparam logic [1:0] ST_DECODED = 2'd0;
    localparam logic [1:0] ST_KEEP    = 2'd1;
    localparam logic [1:0] ST_NAMED   = 2'd2;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [1:0]  status;
        logic [20:0] code;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

### hdl/ncr_front.sv
module ncr_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [7:0]     i_text_byte,
    input  logic           i_is_last,
    input  ncr_pkg::t_q_stat i_q_stat,
    output logic           o_push,
    output ncr_pkg::t_job  o_job
);

    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_UA   = 8'h41;
    localparam logic [7:0] CH_UF   = 8'h46;
    localparam logic [7:0] CH_LA   = 8'h61;
    localparam logic [7:0] CH_LF   = 8'h66;
    localparam logic [7:0] CH_UX   = 8'h58;
    localparam logic [7:0] CH_LX   = 8'h78;

    logic [1:0]  r_pos, n_pos;
    logic        r_numeric, n_numeric;
    logic        r_hex, n_hex;
    logic [20:0] r_code, n_code;
    logic        r_saw, n_saw;
    logic        r_bad, n_bad;

    logic        accept;
    logic        digit_ok;
    logic [3:0]  digit;
    logic [24:0] prod;
    logic [24:0] sum;
    logic [20:0] code_acc;
    logic [20:0] code_fix;
    logic        take;

    assign o_ready = !i_q_stat.full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        digit_ok = 1'b0;
        digit    = 4'd0;
        if (i_text_byte inside {[CH_0:CH_9]}) begin
            digit_ok = 1'b1;
            digit    = i_text_byte[3:0];
        end else if (r_hex && (i_text_byte inside {[CH_LA:CH_LF], [CH_UA:CH_UF]})) begin
            digit_ok = 1'b1;
            digit    = i_text_byte[3:0] + 4'd9;
        end
    end

    always_comb begin
        if (r_hex) begin
            prod = {r_code, 4'b0000};
        end else begin
            prod = {1'b0, r_code, 3'b000} + {3'b000, r_code, 1'b0};
        end
        sum = prod + 25'(digit);
        code_acc = (sum > 25'(ncr_pkg::MAX_CODE)) ? ncr_pkg::SAT_CODE : sum[20:0];
    end

    always_comb begin
        if (r_code == 21'd0 || r_code > ncr_pkg::MAX_CODE ||
            (r_code >= ncr_pkg::SURR_LO && r_code <= ncr_pkg::SURR_HI)) begin
            code_fix = ncr_pkg::REPL_CODE;
        end else begin
            code_fix = r_code;
        end
    end

    always_comb begin
        o_push = accept && i_is_last;
        o_job.code = 21'd0;
        if (!(r_numeric && r_pos == 2'd3)) begin
            o_job.status = ncr_pkg::ST_NAMED;
        end else if (r_bad || !r_saw) begin
            o_job.status = ncr_pkg::ST_KEEP;
        end else begin
            o_job.status = ncr_pkg::ST_DECODED;
            o_job.code   = code_fix;
        end
    end

    always_comb begin
        n_pos     = r_pos;
        n_numeric = r_numeric;
        n_hex     = r_hex;
        n_code    = r_code;
        n_saw     = r_saw;
        n_bad     = r_bad;
        take      = 1'b0;
        if (accept) begin
            if (i_is_last) begin
                n_pos     = 2'd0;
                n_numeric = 1'b0;
                n_hex     = 1'b0;
                n_code    = 21'd0;
                n_saw     = 1'b0;
                n_bad     = 1'b0;
            end else begin
                case (r_pos)
                    2'd1: begin
                        n_numeric = (i_text_byte == CH_HASH);
                    end
                    2'd2: begin
                        if (r_numeric) begin
                            if (i_text_byte == CH_LX || i_text_byte == CH_UX) begin
                                n_hex = 1'b1;
                            end else begin
                                take = 1'b1;
                            end
                        end
                    end
                    2'd3: begin
                        take = r_numeric;
                    end
                    default: begin
                    end
                endcase
                if (take && !r_bad) begin
                    if (digit_ok) begin
                        n_code = code_acc;
                        n_saw  = 1'b1;
                    end else begin
                        n_bad = 1'b1;
                    end
                end
                if (r_pos != 2'd3) begin
                    n_pos = r_pos + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= 2'd0;
            r_numeric <= 1'b0;
            r_hex     <= 1'b0;
            r_code    <= 21'd0;
            r_saw     <= 1'b0;
            r_bad     <= 1'b0;
        end else begin
            r_pos     <= n_pos;
            r_numeric <= n_numeric;
            r_hex     <= n_hex;
            r_code    <= n_code;
            r_saw     <= n_saw;
            r_bad     <= n_bad;
        end
    end

endmodule

### hdl/ncr_fifo.sv
module ncr_fifo #(
    parameter int DEPTH = ncr_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ncr_pkg::t_job    i_job,
    input  logic             i_pop,
    output ncr_pkg::t_job    o_job,
    output ncr_pkg::t_q_stat o_stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    ncr_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [PW:0]   r_count, n_count;
    logic          do_push;
    logic          do_pop;

    assign o_stat.full  = (r_count == (PW+1)'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push = i_push && !o_stat.full;
    assign do_pop  = i_pop && !o_stat.empty;
    assign o_job   = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + (PW+1)'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - (PW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

### hdl/ncr_back.sv
module ncr_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ncr_pkg::t_job i_job,
    input  logic          i_empty,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [7:0]    o_utf8_byte,
    output logic [1:0]    o_status,
    output logic          o_final_byte
);

    logic          r_busy, n_busy;
    ncr_pkg::t_job r_job, n_job;
    logic [1:0]    r_len, n_len;
    logic [1:0]    r_idx, n_idx;
    logic [1:0]    len_in;
    logic [20:0]   cp;

    assign cp           = r_job.code;
    assign o_valid      = r_busy;
    assign o_status     = r_job.status;
    assign o_final_byte = (r_idx == r_len);
    assign o_pop        = !i_empty && (!r_busy || (i_ready && o_final_byte));

    always_comb begin
        if (i_job.status != ncr_pkg::ST_DECODED || i_job.code < ncr_pkg::LIM_1B) begin
            len_in = 2'd0;
        end else if (i_job.code < ncr_pkg::LIM_2B) begin
            len_in = 2'd1;
        end else if (i_job.code < ncr_pkg::LIM_3B) begin
            len_in = 2'd2;
        end else begin
            len_in = 2'd3;
        end
    end

    always_comb begin
        o_utf8_byte = 8'h00;
        if (r_job.status == ncr_pkg::ST_DECODED) begin
            case ({r_len, r_idx})
                4'b0000: o_utf8_byte = {1'b0, cp[6:0]};
                4'b0100: o_utf8_byte = {3'b110, cp[10:6]};
                4'b1000: o_utf8_byte = {4'b1110, cp[15:12]};
                4'b1100: o_utf8_byte = {5'b11110, cp[20:18]};
                4'b1101: o_utf8_byte = {2'b10, cp[17:12]};
                4'b1001, 4'b1110: o_utf8_byte = {2'b10, cp[11:6]};
                4'b0101, 4'b1010, 4'b1111: o_utf8_byte = {2'b10, cp[5:0]};
                default: o_utf8_byte = 8'h00;
            endcase
        end
    end

    always_comb begin
        n_busy = r_busy;
        n_job  = r_job;
        n_len  = r_len;
        n_idx  = r_idx;
        if (o_pop) begin
            n_busy = 1'b1;
            n_job  = i_job;
            n_len  = len_in;
            n_idx  = 2'd0;
        end else if (r_busy && i_ready) begin
            if (o_final_byte) begin
                n_busy = 1'b0;
                n_idx  = 2'd0;
            end else begin
                n_idx = r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
        r_len <= n_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
        end
    end

endmodule

### hdl/numeric_char_ref_to_utf8.sv
// Input: one text byte per cycle; the input stalls only while the job queue is full.
// The closing byte pushes the job into the queue; the encoder pops it into its job register when free.
// Output: one result word per cycle while i_ready is high, from a registered job, one to four words per reference.
// The job queue between the parser and the encoder holds Q_DEPTH finished references.
// Synchronous active-low reset clears the parser state, the queue and the encoder.
module numeric_char_ref_to_utf8 #(
    parameter int Q_DEPTH = ncr_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_text_byte,
    input  logic       i_is_last,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_utf8_byte,
    output logic [1:0] o_status,
    output logic       o_final_byte
);

    logic             push;
    logic             pop;
    ncr_pkg::t_job    job_in;
    ncr_pkg::t_job    job_out;
    ncr_pkg::t_q_stat q_stat;

    ncr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_text_byte (i_text_byte),
        .i_is_last   (i_is_last),
        .i_q_stat    (q_stat),
        .o_push      (push),
        .o_job       (job_in)
    );

    ncr_fifo #(
        .DEPTH (Q_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_job   (job_out),
        .o_stat  (q_stat)
    );

    ncr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job        (job_out),
        .i_empty      (q_stat.empty),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_utf8_byte  (o_utf8_byte),
        .o_status     (o_status),
        .o_final_byte (o_final_byte)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && q_stat.full))
        else $error("job pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(pop && q_stat.empty))
        else $error("job popped from an empty queue");

    a_status_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ncr_pkg::ST_DECODED) |-> (o_final_byte && o_utf8_byte == 8'h00))
        else $error("status word is not a single zero word");

    a_burst_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_final_byte) |=> o_valid)
        else $error("encoding burst broken before its final word");

endmodule
